/* design/hsc_pkg.sv */
`default_nettype none
package hsc_pkg;

    localparam int MAX_CODE_BITS = 64;
    localparam int WORD_W        = 64;
    localparam int CFG_W         = 6;
    localparam int POS_W         = 7;
    localparam int SYN_W         = $clog2(MAX_CODE_BITS);
    localparam int CFG_RESET     = 57;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CFG_W-1:0]  t_cfg;
    typedef logic [SYN_W-1:0]  t_syn;
    typedef logic [POS_W-1:0]  t_pos;

    typedef enum logic [1:0] {
        ST_CLEAN   = 2'd0,
        ST_SINGLE  = 2'd1,
        ST_OVERALL = 2'd2,
        ST_UNCORR  = 2'd3
    } t_status;

    // least m with 2^m >= k + m + 1
    function automatic int parity_count(input int k);
        int m;
        m = 1;
        for (int i = POS_W; i >= 1; i--) begin
            if ((1 << i) >= k + i + 1) begin
                m = i;
            end
        end
        return m;
    endfunction

    function automatic int k_max();
        int k;
        k = 1;
        for (int c = 1; c < MAX_CODE_BITS; c++) begin
            if (c + parity_count(c) + 1 <= MAX_CODE_BITS) begin
                k = c;
            end
        end
        return k;
    endfunction

    localparam int K_MAX = k_max();
    localparam int N_MAX = K_MAX + parity_count(K_MAX);

    // one-based codeword position of data bit d
    function automatic int data_pos(input int d);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int p = 1; p <= MAX_CODE_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == d) begin
                    pos = p;
                end
                cnt++;
            end
        end
        return pos;
    endfunction

    // positions whose index has bit j set
    function automatic t_word col_mask(input int j);
        t_word m;
        m = '0;
        for (int p = 1; p <= WORD_W; p++) begin
            if (((p >> j) & 1) != 0) begin
                m[p-1] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic t_cfg eff_k(input t_cfg v);
        t_cfg k;
        if (v == '0) begin
            k = CFG_W'(1);
        end else if (int'(v) > K_MAX) begin
            k = CFG_W'(K_MAX);
        end else begin
            k = v;
        end
        return k;
    endfunction

    function automatic t_cfg code_n(input t_cfg k);
        t_cfg m;
        m = '0;
        for (int i = POS_W; i >= 1; i--) begin
            if ((POS_W+1)'(1 << i) >= (POS_W+1)'(k) + (POS_W+1)'(i + 1)) begin
                m = CFG_W'(i);
            end
        end
        return k + m;
    endfunction

endpackage
`default_nettype wire

/* design/hsc_in_if.sv */
`default_nettype none
interface hsc_in_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    hsc_pkg::t_word       in_word;

    modport source (output valid, output kind, output in_word, input ready);
    modport sink   (input valid, input kind, input in_word, output ready);
endinterface
`default_nettype wire

/* design/hsc_out_if.sv */
`default_nettype none
interface hsc_out_if;
    logic                 valid;
    logic                 ready;
    hsc_pkg::t_word       out_word;
    logic [1:0]           status;
    hsc_pkg::t_pos        error_position;

    modport source (output valid, output out_word, output status, output error_position,
                    input ready);
    modport sink   (input valid, input out_word, input status, input error_position,
                    output ready);
endinterface
`default_nettype wire

/* design/hamming_secded_codec.sv */
`default_nettype none
// Extended Hamming SECDED encoder/decoder. Each input word is an encode (kind 0: data bits
// from bit 0 become a codeword with parity at power-of-two positions and overall parity at
// bit n) or a decode (kind 1: syndrome check, single-bit correction, double-error detect,
// data extraction). The data width k comes from i_cfg_data (0 acts as 1, large values
// saturate so the codeword fits 64 bits); write it only while the pipe is empty. The
// datapath is four register stages (place, syndrome, correct/insert parity, gather), so a
// word is accepted every cycle when the output is not stalled; a stall freezes the stages
// behind it without dropping anything.
module hamming_secded_codec (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire hsc_pkg::t_cfg        i_cfg_data,
    hsc_in_if.sink                    i_in,
    hsc_out_if.source                 o_out
);

    localparam int W     = hsc_pkg::WORD_W;
    localparam int ND    = hsc_pkg::K_MAX;
    localparam int SW    = hsc_pkg::SYN_W;

    // configuration, derived at reset or write time
    hsc_pkg::t_cfg  r_n;
    hsc_pkg::t_word r_dmask, r_nmask, r_cmask;
    hsc_pkg::t_cfg  n_k, n_n;

    always_comb begin
        n_k = hsc_pkg::eff_k(i_rst_n ? i_cfg_data : hsc_pkg::CFG_W'(hsc_pkg::CFG_RESET));
        n_n = hsc_pkg::code_n(n_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_n     <= n_n;
            r_dmask <= ~({W{1'b1}} << n_k);
            r_nmask <= ~({W{1'b1}} << n_n);
            r_cmask <= ~({W{1'b1}} << (hsc_pkg::POS_W'(n_n) + hsc_pkg::POS_W'(1)));
        end
    end

    // stage enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || o_out.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: place data at non-power-of-two positions, or mask the received codeword
    hsc_pkg::t_word n_word1, scatter, dmasked;
    logic           r_kind1;
    hsc_pkg::t_word r_word1;

    assign dmasked = i_in.in_word & r_dmask;

    for (genvar d = 0; d < ND; d++) begin : g_scatter
        localparam int P = hsc_pkg::data_pos(d);
        assign scatter[P-1] = dmasked[d];
    end
    for (genvar p = 1; p <= W; p++) begin : g_pzero
        if ((p & (p - 1)) == 0 || p > hsc_pkg::data_pos(ND - 1)) begin : g_z
            assign scatter[p-1] = 1'b0;
        end
    end

    assign n_word1 = i_in.kind ? (i_in.in_word & r_cmask) : scatter;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_kind1 <= i_in.kind;
            r_word1 <= n_word1;
        end
    end

    // stage 2: syndrome over positions 1..n, parity over the whole placed word
    hsc_pkg::t_syn  n_syn2;
    logic           r_kind2, r_par2;
    hsc_pkg::t_word r_word2;
    hsc_pkg::t_syn  r_syn2;

    always_comb begin
        for (int j = 0; j < SW; j++) begin
            n_syn2[j] = ^(r_word1 & r_nmask & hsc_pkg::col_mask(j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_kind2 <= r_kind1;
            r_word2 <= r_word1;
            r_syn2  <= n_syn2;
            r_par2  <= ^r_word1;
        end
    end

    // stage 3: insert parity bits (encode) or classify and correct (decode)
    hsc_pkg::t_word  n_word3;
    hsc_pkg::t_status n_status3;
    hsc_pkg::t_pos   n_epos3;
    logic            r_kind3;
    hsc_pkg::t_word  r_word3;
    hsc_pkg::t_status r_status3;
    hsc_pkg::t_pos   r_epos3;

    always_comb begin
        n_word3   = r_word2;
        n_status3 = hsc_pkg::ST_CLEAN;
        n_epos3   = '0;
        if (!r_kind2) begin
            for (int j = 0; j < SW; j++) begin
                n_word3[(1 << j) - 1] = r_syn2[j];
            end
            n_word3[r_n] = r_par2 ^ (^r_syn2);
        end else if (r_syn2 == '0) begin
            if (r_par2) begin
                n_status3 = hsc_pkg::ST_OVERALL;
                n_epos3   = hsc_pkg::POS_W'(r_n) + hsc_pkg::POS_W'(1);
            end
        end else if (!r_par2 || r_syn2 > r_n) begin
            n_status3 = hsc_pkg::ST_UNCORR;
        end else begin
            n_status3 = hsc_pkg::ST_SINGLE;
            n_epos3   = hsc_pkg::POS_W'(r_syn2);
            n_word3   = r_word2 ^ (hsc_pkg::t_word'(1) << (r_syn2 - hsc_pkg::SYN_W'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_kind3   <= r_kind2;
            r_word3   <= n_word3;
            r_status3 <= n_status3;
            r_epos3   <= n_epos3;
        end
    end

    // stage 4: gather data bits back on decode
    hsc_pkg::t_word gather, n_word4;
    hsc_pkg::t_word r_word4;
    hsc_pkg::t_status r_status4;
    hsc_pkg::t_pos  r_epos4;

    for (genvar d = 0; d < W; d++) begin : g_gather
        if (d < ND) begin : g_d
            localparam int P = hsc_pkg::data_pos(d);
            assign gather[d] = r_word3[P-1];
        end else begin : g_z
            assign gather[d] = 1'b0;
        end
    end

    assign n_word4 = r_kind3 ? (gather & r_dmask) : r_word3;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_word4   <= n_word4;
            r_status4 <= r_status3;
            r_epos4   <= r_epos3;
        end
    end

    assign o_out.valid          = r_v4;
    assign o_out.out_word       = r_word4;
    assign o_out.status         = r_status4;
    assign o_out.error_position = r_epos4;

endmodule
`default_nettype wire

/* design/hsc_checker.sv */
`default_nettype none
module hsc_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 i_ready,
    input wire hsc_pkg::t_word       i_word,
    input wire logic [1:0]           i_status,
    input wire hsc_pkg::t_pos        i_epos
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_word) && $stable(i_status)
                                && $stable(i_epos))
        else $error("stalled word changed");

    a_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == hsc_pkg::ST_CLEAN || i_status == hsc_pkg::ST_UNCORR)
            |-> i_epos == '0)
        else $error("error position without a correction");

    a_single_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == hsc_pkg::ST_SINGLE
            |-> i_epos != '0 && i_epos < hsc_pkg::POS_W'(hsc_pkg::MAX_CODE_BITS))
        else $error("single correction at bad position");

    a_overall_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == hsc_pkg::ST_OVERALL
            |-> i_epos > hsc_pkg::POS_W'(3)
                && i_epos <= hsc_pkg::POS_W'(hsc_pkg::MAX_CODE_BITS))
        else $error("overall parity fix at bad position");

endmodule

bind hamming_secded_codec hsc_checker u_hsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_word  (o_out.out_word),
    .i_status(o_out.status),
    .i_epos  (o_out.error_position)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 75;

    typedef struct {
        hsc_pkg::t_word   word;
        hsc_pkg::t_status status;
        hsc_pkg::t_pos    pos;
    } t_codec_result;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_cfg_we   = 1'b0;
    hsc_pkg::t_cfg i_cfg_data = '0;

    t_codec_result codec_results_q[$];
    hsc_pkg::t_cfg width_reg = hsc_pkg::t_cfg'(hsc_pkg::CFG_RESET);
    int            fail_count;
    int            cycle_count;
    int            idle_pct;
    int            stall_pct;
    int            n_encoded;
    int            n_decoded;
    int            n_repaired;
    int            n_uncorrectable;
    int            n_widths = 1;

    hsc_in_if  in_bus();
    hsc_out_if out_bus();

    hamming_secded_codec u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // least m with 2^m >= k + m + 1
    function automatic int check_bits(input int k);
        int m;
        m = 1;
        while ((1 << m) < k + m + 1) m++;
        return m;
    endfunction

    function automatic int width_in_use(input hsc_pkg::t_cfg cfg_val);
        int k;
        k = int'(cfg_val);
        if (k < 1) k = 1;
        while (k > 1 && k + check_bits(k) + 1 > hsc_pkg::MAX_CODE_BITS) k--;
        return k;
    endfunction

    function automatic bit is_check_position(input int p);
        return (p & (p - 1)) == 0;
    endfunction

    function automatic hsc_pkg::t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic t_codec_result codec_predict(input logic dec, input hsc_pkg::t_word w,
                                                    input hsc_pkg::t_cfg cfg_val);
        int             k;
        int             n;
        int             d;
        int             syn;
        int             odd;
        hsc_pkg::t_word cw;
        t_codec_result  r;
        k = width_in_use(cfg_val);
        n = k + check_bits(k);
        r.word   = '0;
        r.status = hsc_pkg::ST_CLEAN;
        r.pos    = '0;
        syn = 0;
        odd = 0;
        d   = 0;
        if (!dec) begin
            for (int p = 1; p <= n; p++) begin
                if (!is_check_position(p)) begin
                    if (w[d]) begin
                        r.word[p-1] = 1'b1;
                        syn ^= p;
                    end
                    d++;
                end
            end
            for (int p = 1; p <= n; p = p * 2) begin
                if ((syn & p) != 0) r.word[p-1] = 1'b1;
            end
            for (int p = 1; p <= n; p++) odd ^= int'(r.word[p-1]);
            r.word[n] = odd[0];
        end else begin
            cw = w;
            for (int p = 1; p <= n + 1; p++) begin
                if (cw[p-1]) begin
                    odd ^= 1;
                    if (p <= n) syn ^= p;
                end
            end
            if (syn == 0 && odd == 0) begin
                r.status = hsc_pkg::ST_CLEAN;
            end else if (syn == 0) begin
                r.status = hsc_pkg::ST_OVERALL;
                r.pos    = hsc_pkg::t_pos'(n + 1);
            end else if (odd == 0 || syn > n) begin
                // double error, or syndrome points past the codeword
                r.status = hsc_pkg::ST_UNCORR;
            end else begin
                r.status = hsc_pkg::ST_SINGLE;
                r.pos    = hsc_pkg::t_pos'(syn);
                cw[syn-1] = ~cw[syn-1];
            end
            for (int p = 1; p <= n; p++) begin
                if (!is_check_position(p)) begin
                    r.word[d] = cw[p-1];
                    d++;
                end
            end
        end
        return r;
    endfunction

    function automatic hsc_pkg::t_word codeword_of(input hsc_pkg::t_word data);
        t_codec_result r;
        r = codec_predict(1'b0, data, width_reg);
        return r.word;
    endfunction

    function automatic hsc_pkg::t_word flip(input hsc_pkg::t_word w, input int p);
        hsc_pkg::t_word f;
        f = w;
        f[p-1] = ~f[p-1];
        return f;
    endfunction

    // receiver backpressure
    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, codec_results_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_codec_result exp_r;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (codec_results_q.size() == 0) begin
                $error("result word with nothing expected: out_word %h", out_bus.out_word);
                fail_count++;
            end else begin
                exp_r = codec_results_q.pop_front();
                if (out_bus.out_word !== exp_r.word) begin
                    $error("out_word: expected %h, got %h", exp_r.word, out_bus.out_word);
                    fail_count++;
                end
                if (out_bus.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, out_bus.status);
                    fail_count++;
                end
                if (out_bus.error_position !== exp_r.pos) begin
                    $error("error_position: expected %0d, got %0d",
                           exp_r.pos, out_bus.error_position);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_word(input logic dec, input hsc_pkg::t_word w);
        t_codec_result r;
        r = codec_predict(dec, w, width_reg);
        while ($urandom_range(99) < idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.kind    <= dec;
        in_bus.in_word <= w;
        do @(posedge i_clk); while (!in_bus.ready);
        codec_results_q.insert(codec_results_q.size(), r);
        if (dec) n_decoded++;
        else n_encoded++;
        if (r.status == hsc_pkg::ST_SINGLE || r.status == hsc_pkg::ST_OVERALL) n_repaired++;
        if (r.status == hsc_pkg::ST_UNCORR) n_uncorrectable++;
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (codec_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input hsc_pkg::t_cfg cfg_val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cfg_val;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        width_reg = cfg_val;
        n_widths++;
    endtask

    task automatic test_encode_extremes();
        send_word(1'b0, '0);
        send_word(1'b0, '1);
        send_word(1'b0, 64'h0123_4567_89ab_cdef);
        send_word(1'b0, hsc_pkg::t_word'(1) << 56);
    endtask

    task automatic test_decode_errors();
        hsc_pkg::t_word cw;
        cw = codeword_of(64'h01a5_a5a5_5a5a_c3c3);
        send_word(1'b1, cw);
        send_word(1'b1, flip(cw, 3));
        send_word(1'b1, flip(cw, 32));
        send_word(1'b1, flip(cw, 63));
        // overall parity bit alone
        send_word(1'b1, flip(cw, 64));
        send_word(1'b1, flip(flip(cw, 5), 40));
    endtask

    task automatic test_syndrome_beyond_codeword();
        hsc_pkg::t_word cw;
        write_width(hsc_pkg::t_cfg'(5));
        cw = codeword_of(64'h15);
        // three flips with syndrome 14, past n = 9
        send_word(1'b1, flip(flip(flip(cw, 2), 4), 8));
        // junk above position n+1 is ignored
        send_word(1'b1, cw | (64'hffff_ffff_ffff_ffff << 10));
        send_word(1'b1, flip(cw, 6) | (64'h5555_5555_5555_5555 << 10));
        send_word(1'b0, 64'hffff_ffff_ffff_ffe0 | 64'h0a);
    endtask

    task automatic test_width_limits();
        write_width(hsc_pkg::t_cfg'(0));
        send_word(1'b0, '1);
        send_word(1'b1, flip(codeword_of(64'h1), 4));
        write_width(hsc_pkg::t_cfg'(63));
        send_word(1'b0, '1);
        send_word(1'b1, flip(codeword_of(rand_word()), 1));
        write_width(hsc_pkg::t_cfg'(1));
        send_word(1'b0, 64'h1);
        send_word(1'b1, flip(codeword_of(64'h0), 3));
    endtask

    task automatic random_item();
        int             k;
        int             n;
        int             pick;
        int             n_flips;
        int             p1;
        int             p2;
        int             p3;
        hsc_pkg::t_word w;
        hsc_pkg::t_word used_mask;
        k = width_in_use(width_reg);
        n = k + check_bits(k);
        used_mask = (n + 1 >= 64) ? '1 : ((hsc_pkg::t_word'(1) << (n + 1)) - 1);
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_word(1'b0, rand_word());
        end else if (pick < 50) begin
            send_word(1'b1, rand_word());
        end else begin
            w = codeword_of(rand_word());
            n_flips = $urandom_range(3);
            p1 = $urandom_range(n + 1, 1);
            do p2 = $urandom_range(n + 1, 1); while (p2 == p1);
            do p3 = $urandom_range(n + 1, 1); while (p3 == p1 || p3 == p2);
            if (n_flips >= 1) w = flip(w, p1);
            if (n_flips >= 2) w = flip(w, p2);
            if (n_flips >= 3) w = flip(w, p3);
            if ($urandom_range(3) == 0) w = w | (rand_word() & ~used_mask);
            send_word(1'b1, w);
        end
    endtask

    task automatic test_random_traffic();
        hsc_pkg::t_cfg widths [6];
        widths = '{hsc_pkg::t_cfg'(57), hsc_pkg::t_cfg'(63), hsc_pkg::t_cfg'(0),
                   hsc_pkg::t_cfg'(11), hsc_pkg::t_cfg'(26),
                   hsc_pkg::t_cfg'($urandom_range(63))};
        for (int ph = 0; ph < 6; ph++) begin
            write_width(widths[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            repeat (PHASE_WORDS) random_item();
        end
    endtask

    initial begin
        in_bus.valid   = 1'b0;
        in_bus.kind    = 1'b0;
        in_bus.in_word = '0;
        out_bus.ready  = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_encode_extremes();
        test_decode_errors();
        test_syndrome_beyond_codeword();
        test_width_limits();
        test_random_traffic();
        wait_idle();

        $display("%0d words encoded, %0d decoded, across %0d data width settings",
                 n_encoded, n_decoded, n_widths);
        $display("%0d decodes repaired a bit, %0d flagged uncorrectable",
                 n_repaired, n_uncorrectable);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/hsc_pkg.sv
design/hsc_in_if.sv
design/hsc_out_if.sv
design/hamming_secded_codec.sv
design/hsc_checker.sv
tb/testbench.sv
